// ===== rtl/triangle_tangent_binormal_macros.svh =====
// Assertion macros shared by the triangle tangent and binormal RTL.
// Depends on nothing; each user provides clk and rst_n in its scope.
`ifndef TRIANGLE_TANGENT_BINORMAL_MACROS_SVH
`define TRIANGLE_TANGENT_BINORMAL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TTB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttb assertion failed");

// Next-cycle implication, checked out of reset.
`define TTB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttb assertion failed");

`endif

// ===== rtl/ttb_pkg.sv =====
// Shared types and constants of the triangle tangent and binormal block.
// Used by the controller, the datapath and the top level.
package ttb_pkg;

  localparam int InW   = 160;
  localparam int OutW  = 96;
  localparam int NumW  = 67;
  localparam int MagW  = 30;
  localparam logic [14:0] UnitQ14 = 15'd16384;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_STORE1 = 4'd1;
  localparam logic [3:0] OP_STORE2 = 4'd2;
  localparam logic [3:0] OP_DELTA  = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_ACC    = 4'd5;
  localparam logic [3:0] OP_LOAD   = 4'd6;
  localparam logic [3:0] OP_SHIFT  = 4'd7;
  localparam logic [3:0] OP_SQ     = 4'd8;
  localparam logic [3:0] OP_SQACC  = 4'd9;
  localparam logic [3:0] OP_RINIT  = 4'd10;
  localparam logic [3:0] OP_RSTEP  = 4'd11;
  localparam logic [3:0] OP_DINIT  = 4'd12;
  localparam logic [3:0] OP_DSTEP  = 4'd13;
  localparam logic [3:0] OP_DSTORE = 4'd14;
  localparam logic [3:0] OP_DEGEN  = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] idx;
    logic       vec;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic mag_zero;
    logic mag_high;
  } status_t;

endpackage

// ===== rtl/ttb_ctrl.sv =====
// Sequencing state machine of the triangle tangent and binormal block.
// Depends on ttb_pkg and the assertion macro header.
`include "triangle_tangent_binormal_macros.svh"
module ttb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  ttb_pkg::status_t stat,
  output ttb_pkg::cmd_t    cmd
);
  import ttb_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_CHKDET = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_SQACC  = 4'd7;
  localparam logic [3:0] S_RINIT  = 4'd8;
  localparam logic [3:0] S_RSTEP  = 4'd9;
  localparam logic [3:0] S_DINIT  = 4'd10;
  localparam logic [3:0] S_DSTEP  = 4'd11;
  localparam logic [3:0] S_DSTORE = 4'd12;
  localparam logic [3:0] S_DEGEN  = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [3:0] p_r, p_nxt;
  logic [1:0] i_r, i_nxt;
  logic [4:0] k_r, k_nxt;
  logic       v_r, v_nxt;
  logic       ov_r, ov_nxt;
  logic       in_acc;

  assign in_tready  = (state_r == S_IDLE) && ((cnt_r != 2'd2) || !ov_r);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    ov_nxt    = ov_r && !out_tready;
    cmd       = '{op: OP_NONE, idx: {2'b00, i_r}, vec: v_r};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (cnt_r)
            2'd0: begin
              cmd.op  = OP_STORE1;
              cnt_nxt = 2'd1;
            end
            2'd1: begin
              cmd.op  = OP_STORE2;
              cnt_nxt = 2'd2;
            end
            default: begin
              cmd.op    = OP_DELTA;
              cnt_nxt   = 2'd0;
              p_nxt     = 4'd0;
              state_nxt = S_MUL;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        cmd.idx   = p_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op  = OP_ACC;
        cmd.idx = p_r;
        if (p_r == 4'd13) begin
          state_nxt = S_CHKDET;
        end else begin
          p_nxt     = p_r + 4'd1;
          state_nxt = S_MUL;
        end
      end
      S_CHKDET: begin
        v_nxt     = 1'b0;
        state_nxt = stat.det_zero ? S_DEGEN : S_LOAD;
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.mag_zero) begin
          state_nxt = S_DEGEN;
        end else if (stat.mag_high) begin
          cmd.op = OP_SHIFT;
        end else begin
          i_nxt     = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = OP_SQACC;
        if (i_r == 2'd2) begin
          state_nxt = S_RINIT;
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_RINIT: begin
        cmd.op    = OP_RINIT;
        k_nxt     = 5'd0;
        state_nxt = S_RSTEP;
      end
      S_RSTEP: begin
        cmd.op = OP_RSTEP;
        if (k_r == 5'd31) begin
          i_nxt     = 2'd0;
          state_nxt = S_DINIT;
        end else begin
          k_nxt = k_r + 5'd1;
        end
      end
      S_DINIT: begin
        cmd.op    = OP_DINIT;
        k_nxt     = 5'd0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (k_r == 5'd14) begin
          state_nxt = S_DSTORE;
        end else begin
          k_nxt = k_r + 5'd1;
        end
      end
      S_DSTORE: begin
        cmd.op = OP_DSTORE;
        if (i_r == 2'd2) begin
          if (v_r) begin
            state_nxt = S_OUT;
          end else begin
            v_nxt     = 1'b1;
            state_nxt = S_LOAD;
          end
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = S_DINIT;
        end
      end
      S_DEGEN: begin
        cmd.op    = OP_DEGEN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
      p_r     <= 4'd0;
      i_r     <= 2'd0;
      k_r     <= 5'd0;
      v_r     <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      p_r     <= p_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      v_r     <= v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  `TTB_ASSERT_IMP(a_busy_not_ready, state_r != S_IDLE, !in_tready)
  `TTB_ASSERT_NXT(a_third_starts, in_acc && (cnt_r == 2'd2), state_r == S_MUL)
  `TTB_ASSERT_IMP(a_out_free_at_start, in_acc && (cnt_r == 2'd2), !ov_r)
  `TTB_ASSERT_NXT(a_out_after_done, state_r == S_OUT, ov_r)

endmodule

// ===== rtl/ttb_dp.sv =====
// Datapath of the triangle tangent and binormal block: corners, shared
// multiplier, numerators, normaliser, square root and divider. Uses ttb_pkg.
module ttb_dp (
  input  logic                    clk,
  input  logic [ttb_pkg::InW-1:0] in_data,
  input  ttb_pkg::cmd_t           cmd,
  output ttb_pkg::status_t        stat,
  output logic [ttb_pkg::OutW-1:0] out_data,
  output logic                    out_degen
);
  import ttb_pkg::*;

  logic [31:0] c1_r [5];
  logic [31:0] c2_r [5];
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [32:0] du1_r, du2_r, dv1_r, dv2_r;
  logic signed [65:0] prod_r;
  logic signed [NumW-1:0] acc_r;
  logic signed [NumW-1:0] num_r [7];
  logic [NumW-1:0] mag_r [3];
  logic            neg_r [3];
  logic [61:0] sum_r;
  logic [63:0] x_r, r_r, bit_r;
  logic [46:0] rem_r, dsh_r;
  logic [14:0] q_r;
  logic [15:0] res_r [6];
  logic        degen_r;

  logic signed [32:0] ma, mb, s1, s2, s3;
  logic [1:0]  ei;
  logic [2:0]  pj;
  logic [NumW-1:0] mor;
  logic [63:0] rt;
  logic [14:0] qc;
  logic [15:0] sres;
  logic [1:0]  ci;

  function automatic logic signed [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    sdiff = $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  assign ci = cmd.idx[1:0];
  assign pj = cmd.idx[3:1];
  assign mor = mag_r[0] | mag_r[1] | mag_r[2];
  assign stat.det_zero = (num_r[0] == '0);
  assign stat.mag_zero = (mor == '0);
  assign stat.mag_high = (mor[NumW-1:MagW] != '0);
  assign rt = r_r + bit_r;
  assign qc = (q_r > UnitQ14) ? UnitQ14 : q_r;
  assign sres = neg_r[ci] ? (16'd0 - {1'b0, qc}) : {1'b0, qc};

  // Operand selection for the shared multiplier.
  always_comb begin
    ei = 2'd0;
    if (pj >= 3'd4) begin
      ei = 2'(pj - 3'd4);
    end else if (pj != 3'd0) begin
      ei = 2'(pj - 3'd1);
    end
    if (cmd.op == OP_SQ) begin
      ma = $signed({3'b000, mag_r[ci][MagW-1:0]});
      mb = ma;
    end else if (pj == 3'd0) begin
      ma = cmd.idx[0] ? du2_r : du1_r;
      mb = cmd.idx[0] ? dv1_r : dv2_r;
    end else if (pj < 3'd4) begin
      ma = cmd.idx[0] ? dv1_r : dv2_r;
      mb = cmd.idx[0] ? e2_r[ei] : e1_r[ei];
    end else begin
      ma = cmd.idx[0] ? du2_r : du1_r;
      mb = cmd.idx[0] ? e1_r[ei] : e2_r[ei];
    end
    s1 = sdiff(c2_r[3], c1_r[3]);
    s2 = sdiff(c2_r[4], c1_r[4]);
    s3 = sdiff(in_data[127:96], c1_r[3]);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_STORE1: begin
        for (int n = 0; n < 5; n++) c1_r[n] <= in_data[32*n +: 32];
      end
      OP_STORE2: begin
        for (int n = 0; n < 5; n++) c2_r[n] <= in_data[32*n +: 32];
      end
      OP_DELTA: begin
        for (int n = 0; n < 3; n++) begin
          e1_r[n] <= sdiff(c2_r[n], c1_r[n]);
          e2_r[n] <= sdiff(in_data[32*n +: 32], c1_r[n]);
        end
        du1_r   <= s1;
        dv1_r   <= s2;
        du2_r   <= s3;
        dv2_r   <= sdiff(in_data[159:128], c1_r[4]);
        degen_r <= 1'b0;
      end
      OP_MUL, OP_SQ: begin
        prod_r <= ma * mb;
      end
      OP_ACC: begin
        if (!cmd.idx[0]) begin
          acc_r <= {prod_r[65], prod_r};
        end else begin
          num_r[pj] <= acc_r - {prod_r[65], prod_r};
        end
      end
      OP_LOAD: begin
        for (int n = 0; n < 3; n++) begin
          if (cmd.vec) begin
            mag_r[n] <= num_r[4+n][NumW-1] ? NumW'(-num_r[4+n]) : num_r[4+n];
            neg_r[n] <= num_r[4+n][NumW-1] ^ num_r[0][NumW-1];
          end else begin
            mag_r[n] <= num_r[1+n][NumW-1] ? NumW'(-num_r[1+n]) : num_r[1+n];
            neg_r[n] <= num_r[1+n][NumW-1] ^ num_r[0][NumW-1];
          end
        end
      end
      OP_SHIFT: begin
        for (int n = 0; n < 3; n++) mag_r[n] <= mag_r[n] >> 1;
      end
      OP_SQACC: begin
        sum_r <= ((ci == 2'd0) ? 62'd0 : sum_r) + prod_r[61:0];
      end
      OP_RINIT: begin
        x_r   <= {2'b00, sum_r};
        r_r   <= 64'd0;
        bit_r <= 64'd1 << 62;
      end
      OP_RSTEP: begin
        if (x_r >= rt) begin
          x_r <= x_r - rt;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DINIT: begin
        rem_r <= {2'b00, mag_r[ci][MagW-1:0], 15'd0} + {16'd0, r_r[30:0]};
        dsh_r <= {1'b0, r_r[30:0], 15'd0};
        q_r   <= 15'd0;
      end
      OP_DSTEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[13:0], 1'b1};
        end else begin
          q_r <= {q_r[13:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_DSTORE: begin
        res_r[{1'b0, ci} + (cmd.vec ? 3'd3 : 3'd0)] <= sres;
      end
      OP_DEGEN: begin
        degen_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int n = 0; n < 6; n++) out_data[16*n +: 16] = degen_r ? 16'd0 : res_r[n];
  end
  assign out_degen = degen_r;

endmodule

// ===== rtl/triangle_tangent_binormal.sv =====
// Top level of the triangle tangent and binormal block.
// Instantiates ttb_ctrl and ttb_dp; uses ttb_pkg.
//
// Usage: vertices arrive on the in_ stream, one transaction per vertex, with
// x, y, z, u and v in signed Q16.16. Every third vertex closes a triangle and
// produces one transaction on the out_ stream: the unit tangent and unit
// binormal in signed Q1.14, with out_tuser set when the triangle is
// degenerate (zero determinant or zero vector), in which case all six
// components are zero. The first two vertices of a triangle are stored and
// give no result.
// After the third vertex the block works through the triangle on one shared
// 33x33 multiplier, a bit-serial square root and a restoring divider: first
// the multiplies and one determinant check, then per vector one shift of the
// numerators per bit that the largest one exceeds 30 bits, the square root
// and the divides. A triangle with a zero determinant skips the vectors. No
// vertex is taken while a triangle is in progress.
// The result stays in the output register until taken; a stalled receiver
// only blocks the third vertex of the next triangle.
// Reset (rst_n low, synchronous) empties the corner count and drops any
// pending result.
module triangle_tangent_binormal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], tex_u [127:96], tex_v [159:128]
  input  logic [ttb_pkg::InW-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z,
  // 16 bits each from bit 0 up
  output logic [ttb_pkg::OutW-1:0] out_tdata,
  // degenerate
  output logic        out_tuser
);
  import ttb_pkg::*;

  cmd_t    cmd;
  status_t stat;

  ttb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ttb_dp u_dp (
    .clk       (clk),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata),
    .out_degen (out_tuser)
  );

endmodule
